// ----- design/tts_pkg.sv -----
// Shared types, constants and helpers of the template tag splitter.
package tts_pkg;

  // Sizing of the piece store and of the length counters
  localparam int MAX_OPEN_PIECES = 16;
  localparam int LENGTH_BITS     = 32;
  localparam int ADDR_W          = (MAX_OPEN_PIECES > 1) ? $clog2(MAX_OPEN_PIECES) : 1;
  localparam int CNT_W           = $clog2(MAX_OPEN_PIECES + 1);
  localparam int LIMIT_W         = 31;
  localparam int CMP_W           = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;

  localparam logic [LIMIT_W-1:0] TAG_LIMIT_RESET = 31'd2147483646;

  // Delimiter bytes
  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;

  // Record kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_TAG  = 2'd1,
    KIND_SUM  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // Add a small increment and stick at the all-ones value
  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] x,
                                                     input logic [1:0] inc);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, x} + {{(LENGTH_BITS - 1){1'b0}}, inc};
    return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
  endfunction

endpackage

// ----- design/tts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/template_tag_splitter_core.sv -----
// Top level of the template tag splitter: byte scanner, piece store and end-of-file flush.
//
// Template bytes enter one per transaction on the s_ group; s_tlast marks the last byte of a
// file. Text runs and tag contents leave as length records on the m_ group (kind in m_tuser),
// the double-brace delimiters being dropped; m_tlast marks the last record caused by one byte.
// A byte that is not the last one is taken whenever the output register is free, so plain
// scanning runs at one byte per cycle while the output is not stalled. The last byte of a
// file starts a flush that walks the piece store of an unclosed tag: for each stored piece a
// registered memory read, then the record; then a step that finds the store exhausted, one for
// the tail piece or pending text and one for the summary, before the next byte is taken.
// Downstream stalls can hold any of the record steps. After an error record, bytes are dropped
// until the last byte of the file, which clears the state without a summary and without a flush.
module template_tag_splitter_core
  import tts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration: tag_length_limit
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] byte_value
  input  logic                 s_tlast,   // end_of_file
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [95:0]          m_tdata,   // [31:0] segment_length, [63:32] segment_total,
                                          // [95:64] content_bytes
  output logic [1:0]           m_tuser,   // [1:0] record_kind
  output logic                 m_tlast    // last_of_run
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_TAIL = 5'b01000,
    ST_SUM  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [LIMIT_W-1:0]     tag_length_limit;
  logic                   inside_tag, inside_tag_next;
  logic                   brace_pending, brace_pending_next;
  logic                   inner_open_pending, inner_open_pending_next;
  logic                   failed, failed_next;
  logic [LENGTH_BITS-1:0] run_length, run_length_next;
  logic [LENGTH_BITS-1:0] piece_length, piece_length_next;
  logic [CNT_W-1:0]       piece_count, piece_count_next;
  logic [CNT_W-1:0]       idx, idx_next;
  logic [31:0]            segment_counter, segment_counter_next;
  logic [31:0]            byte_sum, byte_sum_next;

  logic                   out_free;
  logic                   accept;
  logic                   is_open, is_close;
  logic [LENGTH_BITS-1:0] run_dec, piece_dec;
  logic [LENGTH_BITS-1:0] tail_len;

  logic                   rec_load;
  kind_t                  rec_kind;
  logic [LENGTH_BITS-1:0] rec_len;
  logic [31:0]            rec_tot, rec_bytes;
  logic                   rec_last;
  logic                   do_clear;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [LENGTH_BITS-1:0] ram_wdata, ram_rdata;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign is_open   = (s_tdata == OPEN_BRACE);
  assign is_close  = (s_tdata == CLOSE_BRACE);
  assign run_dec   = run_length - LENGTH_BITS'(1);
  assign piece_dec = piece_length - LENGTH_BITS'(1);
  assign tail_len  = inside_tag ? piece_length
                                : sat_add(run_length, {1'b0, brace_pending});

  // Piece store of an unclosed tag
  tts_ram #(
    .WIDTH (LENGTH_BITS),
    .DEPTH (MAX_OPEN_PIECES)
  ) u_piece_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = piece_count[ADDR_W-1:0];
  assign ram_wdata = piece_dec;
  assign ram_raddr = idx[ADDR_W-1:0];

  // Scan one byte, walk the store at end of file, and build the next record
  always_comb begin
    state_next              = state;
    inside_tag_next         = inside_tag;
    brace_pending_next      = brace_pending;
    inner_open_pending_next = inner_open_pending;
    failed_next             = failed;
    run_length_next         = run_length;
    piece_length_next       = piece_length;
    piece_count_next        = piece_count;
    idx_next                = idx;
    segment_counter_next    = segment_counter;
    byte_sum_next           = byte_sum;
    rec_load                = 1'b0;
    rec_kind                = KIND_TEXT;
    rec_len                 = '0;
    rec_tot                 = '0;
    rec_bytes               = '0;
    rec_last                = 1'b0;
    do_clear                = 1'b0;
    ram_we                  = 1'b0;
    ram_re                  = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next = '0;
          if (!failed) begin
            if (!inside_tag) begin
              // text scanning
              if (is_open) begin
                if (brace_pending) begin
                  if (run_length != '0) begin
                    rec_load = 1'b1;
                    rec_kind = KIND_TEXT;
                    rec_len  = run_length;
                  end
                  inside_tag_next         = 1'b1;
                  run_length_next         = '0;
                  piece_length_next       = '0;
                  piece_count_next        = '0;
                  brace_pending_next      = 1'b0;
                  inner_open_pending_next = 1'b0;
                end else begin
                  brace_pending_next = 1'b1;
                end
              end else begin
                run_length_next    = sat_add(run_length, brace_pending ? 2'd2 : 2'd1);
                brace_pending_next = 1'b0;
              end
            end else if (is_close && brace_pending) begin
              // tag close
              rec_load = 1'b1;
              if (CMP_W'(run_dec) > CMP_W'(tag_length_limit)) begin
                rec_kind    = KIND_ERR;
                failed_next = 1'b1;
              end else begin
                rec_kind                = KIND_TAG;
                rec_len                 = run_dec;
                inside_tag_next         = 1'b0;
                brace_pending_next      = 1'b0;
                inner_open_pending_next = 1'b0;
                run_length_next         = '0;
                piece_length_next       = '0;
                piece_count_next        = '0;
              end
            end else if (is_open && inner_open_pending) begin
              // further opening inside a tag: close the current piece
              if ((piece_dec != '0) && (piece_count >= CNT_W'(MAX_OPEN_PIECES))) begin
                rec_load    = 1'b1;
                rec_kind    = KIND_ERR;
                failed_next = 1'b1;
              end else begin
                if (piece_dec != '0) begin
                  ram_we           = 1'b1;
                  piece_count_next = piece_count + CNT_W'(1);
                end
                piece_length_next       = '0;
                inner_open_pending_next = 1'b0;
                brace_pending_next      = 1'b0;
                run_length_next         = sat_add(run_length, 2'd1);
              end
            end else begin
              run_length_next         = sat_add(run_length, 2'd1);
              piece_length_next       = sat_add(piece_length, 2'd1);
              brace_pending_next      = is_close;
              inner_open_pending_next = is_open;
            end
          end
          // end of file: flush unless an error stands
          if (s_tlast) begin
            if (failed_next) begin
              rec_last = 1'b1;
              do_clear = 1'b1;
            end else begin
              state_next = ST_RD;
            end
          end else begin
            rec_last = 1'b1;
          end
        end
      end
      ST_RD: begin
        if (idx < piece_count) begin
          ram_re     = 1'b1;
          state_next = ST_WAIT;
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          rec_load   = 1'b1;
          rec_kind   = KIND_TEXT;
          rec_len    = ram_rdata;
          idx_next   = idx + CNT_W'(1);
          state_next = ST_RD;
        end
      end
      ST_TAIL: begin
        if (tail_len == '0) begin
          state_next = ST_SUM;
        end else if (out_free) begin
          rec_load   = 1'b1;
          rec_kind   = KIND_TEXT;
          rec_len    = tail_len;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          rec_load   = 1'b1;
          rec_kind   = KIND_SUM;
          rec_tot    = segment_counter;
          rec_bytes  = byte_sum;
          rec_last   = 1'b1;
          do_clear   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // count emitted segments
    if (rec_load && ((rec_kind == KIND_TEXT) || (rec_kind == KIND_TAG))) begin
      segment_counter_next = segment_counter + 32'd1;
      byte_sum_next        = byte_sum + 32'(rec_len);
    end

    // clear per-file state
    if (do_clear) begin
      inside_tag_next         = 1'b0;
      brace_pending_next      = 1'b0;
      inner_open_pending_next = 1'b0;
      run_length_next         = '0;
      piece_length_next       = '0;
      piece_count_next        = '0;
      segment_counter_next    = '0;
      byte_sum_next           = '0;
      failed_next             = 1'b0;
    end
  end

  // Control and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      inside_tag         <= 1'b0;
      brace_pending      <= 1'b0;
      inner_open_pending <= 1'b0;
      failed             <= 1'b0;
      run_length         <= '0;
      piece_length       <= '0;
      piece_count        <= '0;
      idx                <= '0;
      segment_counter    <= '0;
      byte_sum           <= '0;
    end else begin
      state              <= state_next;
      inside_tag         <= inside_tag_next;
      brace_pending      <= brace_pending_next;
      inner_open_pending <= inner_open_pending_next;
      failed             <= failed_next;
      run_length         <= run_length_next;
      piece_length       <= piece_length_next;
      piece_count        <= piece_count_next;
      idx                <= idx_next;
      segment_counter    <= segment_counter_next;
      byte_sum           <= byte_sum_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_length_limit <= TAG_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      tag_length_limit <= cfg_wr_data;
    end
  end

  // Output register: load a record, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rec_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      m_tdata <= {rec_bytes, rec_tot, 32'(rec_len)};
      m_tuser <= rec_kind;
      m_tlast <= rec_last;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    piece_count <= CNT_W'(MAX_OPEN_PIECES))
    else $error("piece count beyond store depth");

  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_SUM)) |-> m_tlast)
    else $error("summary record not marked last");

  a_wait_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> (idx < piece_count))
    else $error("flush read beyond stored pieces");

  a_eof_flush_or_clear: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=>
      ((state == ST_RD) ||
       ((state == ST_IDLE) && !failed && (segment_counter == 32'd0))))
    else $error("last byte neither flushed nor cleared");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the template tag splitter: directed table, then random files.
module tb;
  import tts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 290;
  localparam int SETTLE_CYCLES = 48;   // covers a full-store flush with margin
  localparam int QUIET_LIMIT = 2000;

  // One output record as the block presents it
  typedef struct packed {
    kind_t       kind;
    logic [31:0] len;
    logic [31:0] tot;
    logic [31:0] bytes;
    logic        last;
  } rec_t;

  // One row of the directed table; a typed row carries its own expectation, one record or none
  typedef struct packed {
    logic [7:0]         b;
    logic               eof;
    logic               cfg_en;
    logic [LIMIT_W-1:0] cfg_val;
    logic               typed;
    logic               n_out;
    kind_t              kind;
    logic [31:0]        len;
    logic [31:0]        tot;
    logic [31:0]        bytes;
  } step_t;

  localparam logic Y = 1'b1;
  localparam logic N = 1'b0;
  localparam logic [LIMIT_W-1:0] NOLIM = '0;

  localparam step_t DIRECTED [26] = '{
    // text run closed by an opening, then a one-byte tag
    '{8'h61,       N, N, NOLIM, Y, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, Y, Y, KIND_TEXT, 32'd1, 32'd0, 32'd0},
    '{8'h78,       N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, N, N, NOLIM, Y, Y, KIND_TAG,  32'd1, 32'd0, 32'd0},
    // empty text run is not emitted, empty tag is
    '{OPEN_BRACE,  N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, Y, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, N, N, NOLIM, Y, Y, KIND_TAG,  32'd0, 32'd0, 32'd0},
    '{8'hFF,       Y, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    // unclosed tag split at a further opening, flushed as text pieces
    '{OPEN_BRACE,  N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, Y, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{8'h00,       N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, Y, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    // lone opening brace as the whole file
    '{OPEN_BRACE,  Y, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    // zero limit: tag too long, then bytes ignored up to the last one
    '{OPEN_BRACE,  N, Y, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{8'h80,       N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, N, N, NOLIM, N, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, N, N, NOLIM, Y, Y, KIND_ERR,  32'd0, 32'd0, 32'd0},
    '{CLOSE_BRACE, N, N, NOLIM, Y, N, KIND_TEXT, 32'd0, 32'd0, 32'd0},
    '{OPEN_BRACE,  Y, N, NOLIM, Y, N, KIND_TEXT, 32'd0, 32'd0, 32'd0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [95:0]        m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;

  // Splitter state mirrored by the predictor
  logic [LIMIT_W-1:0]     tag_limit;
  logic                   in_tag;
  logic                   close_seen;   // text: unused '{'; tag: previous byte '}'
  logic                   inner_seen;   // tag: unused '{'
  logic [LENGTH_BITS-1:0] run_len;
  logic [LENGTH_BITS-1:0] piece_len;
  logic [LENGTH_BITS-1:0] piece_lens [MAX_OPEN_PIECES];
  int                     piece_cnt;
  logic [31:0]            seg_cnt;
  logic [31:0]            byte_sum;
  logic                   aborted;

  rec_t       step_recs [$];
  rec_t       pending_records [$];
  logic [7:0] file_bytes [$];

  int   mismatches = 0;
  int   records_seen = 0;
  int   errors_seen = 0;
  int   summaries_seen = 0;
  int   bytes_sent = 0;
  int   files_sent = 0;
  int   cfg_writes = 0;
  int   burst_left = 0;
  int   quiet = 0;
  int   rx_cycle = 0;
  bit   bus_held = 1'b0;

  template_tag_splitter_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [LENGTH_BITS-1:0] bump(input logic [LENGTH_BITS-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic void clear_file_state();
    in_tag = 1'b0;
    close_seen = 1'b0;
    inner_seen = 1'b0;
    run_len = '0;
    piece_len = '0;
    piece_cnt = 0;
    seg_cnt = '0;
    byte_sum = '0;
    aborted = 1'b0;
  endfunction

  function automatic void add_segment(input kind_t k, input logic [LENGTH_BITS-1:0] n);
    seg_cnt = seg_cnt + 32'd1;
    byte_sum = byte_sum + 32'(n);
    step_recs.push_back(rec_t'{kind: k, len: 32'(n), tot: 32'd0, bytes: 32'd0, last: 1'b0});
  endfunction

  function automatic void add_error();
    step_recs.push_back(rec_t'{kind: KIND_ERR, len: 32'd0, tot: 32'd0, bytes: 32'd0,
                               last: 1'b0});
    aborted = 1'b1;
  endfunction

  // Work out the records that one template byte causes and advance the state
  function automatic void split_byte(input logic [7:0] b, input logic eof);
    logic [LENGTH_BITS-1:0] n;
    step_recs = {};
    if (!aborted) begin
      if (!in_tag) begin
        if (b == OPEN_BRACE) begin
          if (close_seen) begin
            if (run_len != '0) add_segment(KIND_TEXT, run_len);
            in_tag = 1'b1;
            run_len = '0;
            piece_len = '0;
            piece_cnt = 0;
            close_seen = 1'b0;
            inner_seen = 1'b0;
          end else begin
            close_seen = 1'b1;
          end
        end else begin
          if (close_seen) begin
            run_len = bump(run_len);
            close_seen = 1'b0;
          end
          run_len = bump(run_len);
        end
      end else if (b == CLOSE_BRACE && close_seen) begin
        n = run_len - 1'b1;
        if (n > LENGTH_BITS'(tag_limit)) begin
          add_error();
        end else begin
          add_segment(KIND_TAG, n);
          in_tag = 1'b0;
          close_seen = 1'b0;
          inner_seen = 1'b0;
          run_len = '0;
          piece_len = '0;
          piece_cnt = 0;
        end
      end else if (b == OPEN_BRACE && inner_seen) begin
        n = piece_len - 1'b1;
        if (n != '0 && piece_cnt >= MAX_OPEN_PIECES) begin
          add_error();
        end else begin
          if (n != '0) begin
            piece_lens[piece_cnt] = n;
            piece_cnt++;
          end
          piece_len = '0;
          inner_seen = 1'b0;
          close_seen = 1'b0;
          run_len = bump(run_len);
        end
      end else begin
        run_len = bump(run_len);
        piece_len = bump(piece_len);
        close_seen = (b == CLOSE_BRACE);
        inner_seen = (b == OPEN_BRACE);
      end
    end
    // last byte: unless aborted, flush what is pending, then the summary; then clear the file state
    if (eof) begin
      if (!aborted) begin
        if (in_tag) begin
          for (int i = 0; i < piece_cnt; i++) add_segment(KIND_TEXT, piece_lens[i]);
          if (piece_len != '0) add_segment(KIND_TEXT, piece_len);
        end else begin
          n = close_seen ? bump(run_len) : run_len;
          if (n != '0) add_segment(KIND_TEXT, n);
        end
        step_recs.push_back(rec_t'{kind: KIND_SUM, len: 32'd0, tot: seg_cnt, bytes: byte_sum,
                                   last: 1'b0});
      end
      clear_file_state();
    end
    if (step_recs.size() != 0) step_recs[step_recs.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- file builder

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == OPEN_BRACE || v == CLOSE_BRACE);
    return v;
  endfunction

  function automatic void add_plain(input int count);
    repeat (count) file_bytes.push_back(plain_byte());
  endfunction

  function automatic void add_pair(input logic [7:0] brace);
    file_bytes.push_back(brace);
    file_bytes.push_back(brace);
  endfunction

  // Well-formed templates half the time, else unclosed tags (deep ones can fill the piece store) or noise
  function automatic void build_file();
    int shape;
    int pieces;
    bit deep;
    file_bytes = {};
    shape = $urandom_range(0, 9);
    if (shape < 5) begin
      repeat ($urandom_range(1, 4)) begin
        add_plain($urandom_range(0, 5));
        add_pair(OPEN_BRACE);
        if ($urandom_range(0, 3) == 0) add_plain($urandom_range(7, 12));
        else add_plain($urandom_range(0, 5));
        add_pair(CLOSE_BRACE);
      end
      add_plain($urandom_range(0, 4));
    end else if (shape < 8) begin
      deep = ($urandom_range(0, 1) == 1);
      pieces = deep ? $urandom_range(14, 20) : $urandom_range(0, 6);
      add_plain($urandom_range(0, 3));
      add_pair(OPEN_BRACE);
      repeat (pieces) begin
        add_plain($urandom_range(deep ? 1 : 0, 3));
        add_pair(OPEN_BRACE);
      end
      add_plain($urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 2))
          0: file_bytes.push_back(OPEN_BRACE);
          1: file_bytes.push_back(CLOSE_BRACE);
          default: file_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic release_bus();
    s_tvalid <= 1'b0;
    bus_held = 1'b0;
  endtask

  // Offer one byte, wait for the transaction, then predict its records
  task automatic send_byte(input logic [7:0] b, input logic eof, input bit typed_row);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eof;
    bus_held = 1'b1;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (eof) files_sent++;
    split_byte(b, eof);
    if (!typed_row) begin
      foreach (step_recs[i]) pending_records.push_back(step_recs[i]);
    end
  endtask

  // Hold valid through a burst, drop it for a random gap between bursts
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      release_bus();
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0);
      pace();
    end
  endtask

  // Wait until every expected record is in, then let a flush without records finish
  task automatic drain();
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tag_limit = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------- receiver and checker

  // Stall pattern: always ready, then random, then a repeating pattern on the cycle count
  always @(posedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 200) % 3)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 2) != 0);
      default: m_tready <= ((rx_cycle % 5) >= 3);
    endcase
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each record transaction with the oldest expectation; watch for a hang
  always @(posedge clk) begin
    rec_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        records_seen++;
        if (m_tuser == KIND_ERR) errors_seen++;
        if (m_tuser == KIND_SUM) summaries_seen++;
        if (pending_records.size() == 0) begin
          $display("%0t: unexpected record kind %0d length 0x%0h", $time, m_tuser,
                   m_tdata[31:0]);
          mismatches++;
        end else begin
          want = pending_records.pop_front();
          check_field("record_kind", 32'(want.kind), 32'(m_tuser));
          check_field("segment_length", want.len, m_tdata[31:0]);
          check_field("segment_total", want.tot, m_tdata[63:32]);
          check_field("content_bytes", want.bytes, m_tdata[95:64]);
          check_field("last_of_run", 32'(want.last), 32'(m_tlast));
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) ||
          (!s_tvalid && pending_records.size() == 0)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
          $display("template_tag_splitter_core: mismatch");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int ph;
    ph = 0;
    tag_limit = TAG_LIMIT_RESET;
    clear_file_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].cfg_en) begin
        if (bus_held) release_bus();
        drain();
        write_limit(DIRECTED[i].cfg_val);
      end
      send_byte(DIRECTED[i].b, DIRECTED[i].eof, DIRECTED[i].typed);
      if (DIRECTED[i].typed && DIRECTED[i].n_out) begin
        pending_records.push_back(rec_t'{kind: DIRECTED[i].kind, len: DIRECTED[i].len,
                                         tot: DIRECTED[i].tot, bytes: DIRECTED[i].bytes,
                                         last: 1'b1});
      end
      pace();
    end

    // random files in phases, each under its own tag limit
    while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
      if (bus_held) release_bus();
      drain();
      case (ph % 4)
        0: write_limit(TAG_LIMIT_RESET);
        1: write_limit('0);
        2: write_limit(LIMIT_W'($urandom_range(1, 6)));
        default: write_limit(LIMIT_W'($urandom_range(0, 2147483646)));
      endcase
      repeat ($urandom_range(3, 5)) begin
        if (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
          build_file();
          send_file();
        end
      end
      ph++;
    end

    if (bus_held) release_bus();
    drain();

    $display("Sent %0d bytes in %0d files across %0d tag-limit writes.", bytes_sent,
             files_sent, cfg_writes);
    $display("Checked %0d records, %0d of them errors and %0d summaries.", records_seen,
             errors_seen, summaries_seen);
    if (mismatches == 0) begin
      $display("template_tag_splitter_core: match");
    end else begin
      $display("template_tag_splitter_core: mismatch");
    end
    $finish;
  end

endmodule
